// ===== design/turtle_vector_plotter_assert.svh =====
// Assertion macros for the turtle vector plotter.
// Included by the top level; no other dependencies.
`ifndef TURTLE_VECTOR_PLOTTER_ASSERT_SVH
`define TURTLE_VECTOR_PLOTTER_ASSERT_SVH
`ifndef SYNTH
`define TVP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define TVP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`define TVP_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);
`else
`define TVP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define TVP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`define TVP_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== design/tvp_pkg.sv =====
// Shared types, constants and the arctangent table of the turtle vector plotter.
// No dependencies; imported by every module of the block.
`default_nettype none

package tvp_pkg;

   localparam int DataW       = 32;
   localparam int ReqUserW    = 3;
   localparam int RspDataW    = 168;
   localparam int AddrW       = 4;

   localparam int CordicSteps = 24;
   localparam int StepW       = 5;
   localparam int GuardBits   = 8;
   localparam int PreShift    = 30 - GuardBits;
   localparam int XW          = 42;
   localparam int ZW          = 34;
   localparam int DeltaW      = 34;
   localparam int ProdW       = 64;
   localparam int AtanW       = 30;

   // turn scaling: delta = (deg * 2^16 + 180) / 360 = (deg * 2^13 + 22) / 45
   localparam int MagHiW      = 16;
   localparam int HiStepW     = 24;
   localparam int HiProdW     = MagHiW + HiStepW;
   localparam int TurnHiShift = 5;
   localparam int TurnLoShift = 13;
   localparam int TurnRemW    = 30;
   localparam int RecipW      = 31;
   localparam int RecipProdW  = TurnRemW + RecipW;
   localparam int RecipShift  = 36;

   localparam logic signed [DataW-1:0]  InvGain     = 32'sd652032874;
   localparam logic signed [ProdW-1:0]  PreRound    = 64'sd2097152;
   localparam logic signed [XW-1:0]     GuardRound  = 42'sd128;
   localparam logic signed [ZW-1:0]     QuarterTurn = 34'sh0_4000_0000;
   localparam logic signed [ZW-1:0]     HalfTurn    = 34'sh0_8000_0000;
   localparam logic [DataW-1:0]         HalfTurnBa  = 32'h8000_0000;
   // 2^29 = 45 * TurnHiStep + 2^TurnHiShift
   localparam logic [HiStepW-1:0]       TurnHiStep  = 24'd11930464;
   // ceil(2^36 / 45), exact for dividends below 2^30
   localparam logic [RecipW-1:0]        TurnRecip   = 31'd1527099484;
   localparam logic [TurnRemW-1:0]      TurnBias    = 30'd22;
   localparam logic signed [DeltaW:0]   SatMax      = 35'sd2147483647;
   localparam logic signed [DeltaW:0]   SatMin      = -35'sd2147483648;

   typedef enum logic [2:0] {
      OP_FORWARD  = 3'd0,
      OP_BACKWARD = 3'd1,
      OP_LEFT     = 3'd2,
      OP_RIGHT    = 3'd3,
      OP_PEN_UP   = 3'd4,
      OP_PEN_DOWN = 3'd5,
      OP_HOME     = 3'd6
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_HOME_X       = 2'd0,
      CSR_HOME_Y       = 2'd1,
      CSR_HOME_HEADING = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOVE,
      ST_TURN,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      CP_IDLE,
      CP_MUL,
      CP_PRE,
      CP_ROT,
      CP_RND
   } cordic_state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_SPLIT,
      DV_MUL,
      DV_FIX
   } div_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // atan(2^-i) as a binary angle, full turn 2^32
   function automatic logic [AtanW-1:0] atan_lookup(input logic [StepW-1:0] idx);
      logic [AtanW-1:0] val;
      case (idx)
         5'd0:    val = 30'd536870912;
         5'd1:    val = 30'd316933406;
         5'd2:    val = 30'd167458907;
         5'd3:    val = 30'd85004756;
         5'd4:    val = 30'd42667331;
         5'd5:    val = 30'd21354465;
         5'd6:    val = 30'd10679838;
         5'd7:    val = 30'd5340245;
         5'd8:    val = 30'd2670163;
         5'd9:    val = 30'd1335087;
         5'd10:   val = 30'd667544;
         5'd11:   val = 30'd333772;
         5'd12:   val = 30'd166886;
         5'd13:   val = 30'd83443;
         5'd14:   val = 30'd41722;
         5'd15:   val = 30'd20861;
         5'd16:   val = 30'd10430;
         5'd17:   val = 30'd5215;
         5'd18:   val = 30'd2608;
         5'd19:   val = 30'd1304;
         5'd20:   val = 30'd652;
         5'd21:   val = 30'd326;
         5'd22:   val = 30'd163;
         5'd23:   val = 30'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== design/tvp_cordic.sv =====
// Iterative CORDIC rotator: folds the angle, prescales by 1/K, rotates in 24 steps.
// Depends on tvp_pkg.
`default_nettype none

module tvp_cordic import tvp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DataW-1:0]  dist_in,
   input  logic [DataW-1:0]         angle_in,
   output unit_stat_type            stat,
   output logic signed [DeltaW-1:0] dx_out,
   output logic signed [DeltaW-1:0] dy_out
);

   cordic_state_type          state_ff, state_in;
   logic [StepW-1:0]          step_ff;
   logic                      done_ff;
   logic signed [DataW:0]     dist_ff;
   logic signed [ProdW-1:0]   prod_ff;
   logic signed [XW-1:0]      x_ff, y_ff;
   logic signed [ZW-1:0]      z_ff;
   logic signed [DeltaW-1:0]  dx_ff, dy_ff;

   logic signed [ZW-1:0]      z_raw, z_fold, atan_ext, z_step;
   logic                      fold_hi, fold_lo;
   logic signed [DataW:0]     dist_ext, dist_fold;
   logic signed [ProdW-1:0]   pre_sum;
   logic signed [XW-1:0]      xs, ys, x_step, y_step, x_rnd, y_rnd;

   // fold the angle into plus or minus a quarter turn, flip the distance to match
   always_comb begin
      z_raw     = {{(ZW-DataW){angle_in[DataW-1]}}, angle_in};
      fold_hi   = z_raw > QuarterTurn;
      fold_lo   = z_raw < -QuarterTurn;
      dist_ext  = {dist_in[DataW-1], dist_in};
      dist_fold = (fold_hi || fold_lo) ? -dist_ext : dist_ext;
      if (fold_hi) begin
         z_fold = z_raw - HalfTurn;
      end else if (fold_lo) begin
         z_fold = z_raw + HalfTurn;
      end else begin
         z_fold = z_raw;
      end
   end

   always_comb begin
      pre_sum  = prod_ff + PreRound;
      xs       = x_ff >>> step_ff;
      ys       = y_ff >>> step_ff;
      atan_ext = {{(ZW-AtanW){1'b0}}, atan_lookup(step_ff)};
      if (!z_ff[ZW-1]) begin
         x_step = x_ff - ys;
         y_step = y_ff + xs;
         z_step = z_ff - atan_ext;
      end else begin
         x_step = x_ff + ys;
         y_step = y_ff - xs;
         z_step = z_ff + atan_ext;
      end
      x_rnd = x_ff + GuardRound;
      y_rnd = y_ff + GuardRound;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CP_IDLE: begin
            if (start) state_in = CP_MUL;
         end
         CP_MUL:  state_in = CP_PRE;
         CP_PRE:  state_in = CP_ROT;
         CP_ROT: begin
            if (step_ff == StepW'(CordicSteps - 1)) state_in = CP_RND;
         end
         CP_RND:  state_in = CP_IDLE;
         default: state_in = CP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == CP_RND);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         CP_IDLE: begin
            if (start) begin
               dist_ff <= dist_fold;
               z_ff    <= z_fold;
            end
         end
         CP_MUL: prod_ff <= dist_ff * InvGain;
         CP_PRE: begin
            x_ff    <= pre_sum[PreShift +: XW];
            y_ff    <= '0;
            step_ff <= '0;
         end
         CP_ROT: begin
            x_ff    <= x_step;
            y_ff    <= y_step;
            z_ff    <= z_step;
            step_ff <= step_ff + StepW'(1);
         end
         CP_RND: begin
            dx_ff <= x_rnd[GuardBits +: DeltaW];
            dy_ff <= y_rnd[GuardBits +: DeltaW];
         end
         default: ;
      endcase
   end

   assign stat.busy = (state_ff != CP_IDLE);
   assign stat.done = done_ff;
   assign dx_out    = dx_ff;
   assign dy_out    = dy_ff;

endmodule

`default_nettype wire

// ===== design/tvp_div360.sv =====
// Turn scaler: degrees to a binary angle step by reciprocal multiplication: split, multiply, fix-up.
// Depends on tvp_pkg.
`default_nettype none

module tvp_div360 import tvp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DataW-1:0] deg_in,
   output unit_stat_type           stat,
   output logic [DataW-1:0]        delta_out
);

   div_state_type           state_ff, state_in;
   logic                    neg_ff, done_ff;
   logic [DataW-1:0]        mag_ff;
   logic [TurnRemW-1:0]     low_ff;
   logic [DataW-1:0]        hi_ff;
   logic [RecipProdW-1:0]   prod_ff;
   logic [DataW-1:0]        delta_ff;

   logic [DataW-1:0]        mag;
   logic [TurnRemW-1:0]     low_sum;
   logic [HiProdW-1:0]      hi_prod;
   logic [DataW-1:0]        quot;

   // split the magnitude at bit 16: the upper half goes through 2^29 / 45 directly,
   // its remainder joins the lower half for the reciprocal divide by 45
   always_comb begin
      mag     = deg_in[DataW-1] ? DataW'(-deg_in) : DataW'(deg_in);
      low_sum = {{(TurnRemW-MagHiW-TurnHiShift){1'b0}}, mag_ff[DataW-1:MagHiW],
                 {TurnHiShift{1'b0}}}
              + {{(TurnRemW-MagHiW-TurnLoShift){1'b0}}, mag_ff[MagHiW-1:0],
                 {TurnLoShift{1'b0}}}
              + TurnBias;
      hi_prod = mag_ff[DataW-1:MagHiW] * TurnHiStep;
      quot    = hi_ff + DataW'(prod_ff[RecipProdW-1:RecipShift]);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DV_IDLE: begin
            if (start) state_in = DV_SPLIT;
         end
         DV_SPLIT: state_in = DV_MUL;
         DV_MUL:   state_in = DV_FIX;
         DV_FIX:   state_in = DV_IDLE;
         default:  state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == DV_FIX);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         DV_IDLE: begin
            if (start) begin
               mag_ff <= mag;
               neg_ff <= deg_in[DataW-1];
            end
         end
         DV_SPLIT: begin
            low_ff <= low_sum;
            hi_ff  <= hi_prod[DataW-1:0];
         end
         DV_MUL: prod_ff <= low_ff * TurnRecip;
         DV_FIX: begin
            delta_ff <= neg_ff ? -quot : quot;
         end
         default: ;
      endcase
   end

   assign stat.busy = (state_ff != DV_IDLE);
   assign stat.done = done_ff;
   assign delta_out = delta_ff;

endmodule

`default_nettype wire

// ===== design/turtle_vector_plotter.sv =====
// Top level of the turtle vector plotter: register port, command sequencer, turtle state.
// Depends on tvp_pkg, tvp_cordic, tvp_div360 and turtle_vector_plotter_assert.svh.
//
//   channel | dir | signals                  | word
//   req     | in  | tvalid tready tdata tuser| one command: opcode, amount
//   rsp     | out | tvalid tready tdata tuser| one segment per command
//   csr     | in  | APB, pready tied high    | home_x, home_y, home_heading
//
// A move runs through prescale multiply, prescale rounding, 24 passes through the
// shared CORDIC step, a rounding pass, handover and commit. A turn runs through split,
// reciprocal multiply, fix-up, handover and commit; pen, home and the unused code go
// straight to commit. Input is ready again the cycle after commit.
// A finished word waits in the output register; a new command is taken meanwhile.
// Reset is synchronous and clears position, heading and home values, pen down.
`default_nettype none
`include "turtle_vector_plotter_assert.svh"

module turtle_vector_plotter import tvp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [DataW-1:0]    req_tdata,   // amount
   input  logic [ReqUserW-1:0] req_tuser,   // opcode
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // from_x, from_y, to_x, to_y, heading_now, pen_state, zero fill
   output logic [RspDataW-1:0] rsp_tdata,
   output logic [0:0]          rsp_tuser,   // drawn
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [AddrW-1:0]    csr_paddr,
   input  logic [DataW-1:0]    csr_pwdata,
   output logic [DataW-1:0]    csr_prdata,
   output logic                csr_pready
);

   state_type                 state_ff, state_in;
   opcode_type                op_ff;
   logic [DataW-1:0]          home_x_ff, home_y_ff, home_heading_ff;
   logic [DataW-1:0]          pos_x_ff, pos_y_ff, heading_ff;
   logic                      pen_ff;
   logic                      rsp_valid_ff;
   logic [RspDataW-1:0]       rsp_data_ff;
   logic                      rsp_drawn_ff;

   opcode_type                req_op;
   logic                      req_acc, is_move, is_turn, out_free, commit, csr_write;
   logic [DataW-1:0]          move_angle;
   unit_stat_type             cordic_stat, div_stat;
   logic signed [DeltaW-1:0]  dx, dy;
   logic [DataW-1:0]          delta;

   logic [DataW-1:0]          pos_x_in, pos_y_in, heading_in;
   logic                      pen_in, drawn_in;

   function automatic logic [DataW-1:0] sat_add(input logic [DataW-1:0] p,
                                                 input logic signed [DeltaW-1:0] d);
      logic signed [DeltaW:0] s;
      logic [DataW-1:0]       r;
      s = signed'({{(DeltaW+1-DataW){p[DataW-1]}}, p}) + {d[DeltaW-1], d};
      if (s > SatMax) begin
         r = SatMax[DataW-1:0];
      end else if (s < SatMin) begin
         r = SatMin[DataW-1:0];
      end else begin
         r = s[DataW-1:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- handshake
   always_comb begin
      req_op     = opcode_type'(req_tuser);
      req_tready = (state_ff == ST_IDLE);
      req_acc    = req_tvalid && req_tready;
      is_move    = req_op inside {OP_FORWARD, OP_BACKWARD};
      is_turn    = req_op inside {OP_LEFT, OP_RIGHT};
      move_angle = (req_op == OP_BACKWARD) ? heading_ff + HalfTurnBa : heading_ff;
      out_free   = !rsp_valid_ff || rsp_tready;
      commit     = (state_ff == ST_DONE) && out_free;
   end

   tvp_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .start    (req_acc && is_move),
      .dist_in  (signed'(req_tdata)),
      .angle_in (move_angle),
      .stat     (cordic_stat),
      .dx_out   (dx),
      .dy_out   (dy)
   );

   tvp_div360 u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (req_acc && is_turn),
      .deg_in    (signed'(req_tdata)),
      .stat      (div_stat),
      .delta_out (delta)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (is_move) begin
                  state_in = ST_MOVE;
               end else if (is_turn) begin
                  state_in = ST_TURN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MOVE: begin
            if (cordic_stat.done) state_in = ST_DONE;
         end
         ST_TURN: begin
            if (div_stat.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // next turtle state from the finished command
   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      heading_in = heading_ff;
      pen_in     = pen_ff;
      drawn_in   = 1'b0;
      case (op_ff)
         OP_FORWARD, OP_BACKWARD: begin
            pos_x_in = sat_add(pos_x_ff, dx);
            pos_y_in = sat_add(pos_y_ff, dy);
            drawn_in = pen_ff;
         end
         OP_LEFT:     heading_in = heading_ff - delta;
         OP_RIGHT:    heading_in = heading_ff + delta;
         OP_PEN_UP:   pen_in = 1'b0;
         OP_PEN_DOWN: pen_in = 1'b1;
         OP_HOME: begin
            pos_x_in   = home_x_ff;
            pos_y_in   = home_y_ff;
            heading_in = home_heading_ff;
            pen_in     = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= '0;
         pen_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            pos_x_ff     <= pos_x_in;
            pos_y_ff     <= pos_y_in;
            heading_ff   <= heading_in;
            pen_ff       <= pen_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload: hold the opcode, load the output word on commit
   always_ff @(posedge clock) begin
      if (req_acc) op_ff <= req_op;
      if (commit) begin
         rsp_drawn_ff <= drawn_in;
         rsp_data_ff  <= {{(RspDataW - 5*DataW - 1){1'b0}}, pen_in, heading_in,
                          pos_y_in, pos_x_in, pos_y_ff, pos_x_ff};
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_drawn_ff;

   // ---------------------------------------------------------------- registers
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         home_x_ff       <= '0;
         home_y_ff       <= '0;
         home_heading_ff <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_paddr[AddrW-1:2]))
            CSR_HOME_X:       home_x_ff       <= csr_pwdata;
            CSR_HOME_Y:       home_y_ff       <= csr_pwdata;
            CSR_HOME_HEADING: home_heading_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index_type'(csr_paddr[AddrW-1:2]))
         CSR_HOME_X:       csr_prdata = home_x_ff;
         CSR_HOME_Y:       csr_prdata = home_y_ff;
         CSR_HOME_HEADING: csr_prdata = home_heading_ff;
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- checks
   `TVP_ASSERT_NEXT(a_move_starts, clock, reset, req_acc && is_move, state_ff == ST_MOVE && cordic_stat.busy, "move did not start the rotator")
   `TVP_ASSERT_NEVER(a_ready_while_busy, clock, reset, req_tready && (cordic_stat.busy || div_stat.busy), "ready while a unit is busy")
   `TVP_ASSERT_IMPLY(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE, "result word outside commit")
   `TVP_ASSERT_NEVER(a_cordic_done_in_move, clock, reset, cordic_stat.done && state_ff != ST_MOVE, "rotator finished outside a move")

endmodule

`default_nettype wire
